[src/dlse_pkg.sv]
// Package for the decimal LCD segment encoder: widths, the double-dabble
// stage type and the digit-to-segment table. No dependencies.
package dlse_pkg;

   // Input and conversion widths.
   localparam int ValueWidth  = 20;
   localparam int DabbleDigits = 7;
   localparam int BcdWidth    = 4 * DabbleDigits;
   localparam int ShownDigits = 6;
   localparam int ShownWidth  = 4 * ShownDigits;

   // Pipeline split: shift steps per stage and the number of stages.
   localparam int StageSteps = 5;
   localparam int StageCount = ValueWidth / StageSteps;

   // Row index of the final result of a transaction.
   localparam logic [1:0] LastRow = 2'd3;

   // Conversion state carried between stages.
   typedef struct packed {
      logic [BcdWidth-1:0]   bcd;
      logic [ValueWidth-1:0] bin;
   } dabble_type;

   // Segment nibble for one decimal digit on one common row.
   function automatic logic [3:0] seg_nibble(input logic [3:0] digit, input logic [1:0] row);
      logic [15:0] rows;
      unique case (digit)
         4'd0:    rows = {4'h1, 4'h5, 4'h5, 4'h1};
         4'd1:    rows = {4'h0, 4'h1, 4'h1, 4'h0};
         4'd2:    rows = {4'h1, 4'hE, 4'h1, 4'h1};
         4'd3:    rows = {4'h1, 4'hB, 4'h1, 4'h1};
         4'd4:    rows = {4'h0, 4'hB, 4'h5, 4'h0};
         4'd5:    rows = {4'h1, 4'hB, 4'h4, 4'h1};
         4'd6:    rows = {4'h1, 4'hF, 4'h4, 4'h1};
         4'd7:    rows = {4'h0, 4'h1, 4'h1, 4'h1};
         4'd8:    rows = {4'h1, 4'hF, 4'h5, 4'h1};
         4'd9:    rows = {4'h1, 4'hB, 4'h5, 4'h1};
         default: rows = 16'h0000;
      endcase
      // Row 0 sits in the low nibble of the packed row list.
      return rows[4*row +: 4];
   endfunction

endpackage

[src/dlse_dabble_stage.sv]
// One pipeline stage of the binary-to-BCD conversion: StageSteps double-dabble
// shift steps followed by a register with a valid bit. Uses dlse_pkg.
module dlse_dabble_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  dlse_pkg::dabble_type in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output dlse_pkg::dabble_type out_data
);
   import dlse_pkg::*;

   logic       valid_ff;
   dabble_type data_ff;
   dabble_type data_in;

   // Shift-and-add-three steps of this stage.
   always_comb begin
      data_in = in_data;
      for (int k = 0; k < StageSteps; k++) begin
         for (int j = 0; j < DabbleDigits; j++) begin
            if (data_in.bcd[4*j +: 4] >= 4'd5) begin
               data_in.bcd[4*j +: 4] = data_in.bcd[4*j +: 4] + 4'd3;
            end
         end
         data_in = dabble_type'({data_in.bcd[BcdWidth-2:0], data_in.bin, 1'b0});
      end
   end

   // The stage holds while it has data that the next stage refuses.
   assign in_stall = valid_ff & out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[src/decimal_lcd_segment_encoder.sv]
// Top level of the decimal LCD segment encoder: conversion pipeline and
// row serializer. Uses dlse_pkg and dlse_dabble_stage.
//
// Usage: a 20-bit unsigned number enters on the req_ channel; each
// transaction yields four transactions on the rsp_ channel, one for each
// LCD common row 0 to 3 in order, rsp_last marking row 3. Each carries the
// three data bytes of the six low decimal digits (units in the high nibble
// of rsp_byte_right, the 10^5 digit in the low nibble of rsp_byte_left).
// Row 0 of a number appears once it has passed the registers of the
// four conversion stages of five double-dabble steps each and the
// row serializer register. The serializer drives the four rows of a
// number one per cycle while the receiver does not stall, and loads the
// next number in the cycle its last row is taken; the pipeline keeps
// accepting numbers until all its stages are full.
// Reset clears all valid bits; nothing else needs clearing. When the
// receiver stalls, the current row holds and the stall backs up stage by
// stage to req_stall; nothing is lost or repeated.
module decimal_lcd_segment_encoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dlse_pkg::ValueWidth-1:0]    req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_row,
   output logic [7:0]                         rsp_byte_left,
   output logic [7:0]                         rsp_byte_middle,
   output logic [7:0]                         rsp_byte_right,
   output logic                               rsp_last
);
   import dlse_pkg::*;

   logic       stage_valid [0:StageCount];
   logic       stage_stall [0:StageCount];
   dabble_type stage_data  [0:StageCount];

   logic                  ser_valid_ff;
   logic [1:0]            row_ff;
   logic [ShownWidth-1:0] digits_ff;
   logic                  ser_done;
   logic                  rsp_take;

   // Pipeline entry: empty BCD field, binary value to shift out.
   assign stage_valid[0] = req_valid;
   assign stage_data[0]  = '{bcd: '0, bin: req_value};
   assign req_stall      = stage_stall[0];

   // Conversion stages.
   for (genvar s = 0; s < StageCount; s++) begin : g_stage
      dlse_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[s]),
         .in_stall  (stage_stall[s]),
         .in_data   (stage_data[s]),
         .out_valid (stage_valid[s+1]),
         .out_stall (stage_stall[s+1]),
         .out_data  (stage_data[s+1])
      );
   end

   // The serializer frees up in the cycle its last row is taken.
   assign rsp_take = ser_valid_ff & !rsp_stall;
   assign ser_done = rsp_take & (row_ff == LastRow);
   assign stage_stall[StageCount] = ser_valid_ff & !ser_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         row_ff       <= 2'd0;
      end else if (!stage_stall[StageCount]) begin
         ser_valid_ff <= stage_valid[StageCount];
         row_ff       <= 2'd0;
      end else if (rsp_take) begin
         row_ff <= row_ff + 2'd1;
      end
   end

   // Only the six low digits are displayed; the seventh is dropped.
   always_ff @(posedge clock) begin
      if (!stage_stall[StageCount]) begin
         digits_ff <= stage_data[StageCount].bcd[ShownWidth-1:0];
      end
   end

   // Segment lookup for the current row.
   assign rsp_valid       = ser_valid_ff;
   assign rsp_row         = row_ff;
   assign rsp_last        = (row_ff == LastRow);
   assign rsp_byte_left   = {seg_nibble(digits_ff[19:16], row_ff),
                             seg_nibble(digits_ff[23:20], row_ff)};
   assign rsp_byte_middle = {seg_nibble(digits_ff[11:8], row_ff),
                             seg_nibble(digits_ff[15:12], row_ff)};
   assign rsp_byte_right  = {seg_nibble(digits_ff[3:0], row_ff),
                             seg_nibble(digits_ff[7:4], row_ff)};

`ifndef NO_ASSERTIONS
   // A taken row other than the last is followed by the next row.
   a_row_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> (rsp_valid && rsp_row == $past(rsp_row) + 2'd1))
      else $error("row sequence broken");

   // A result that starts after rsp_valid was low begins at row 0.
   a_row_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_row == 2'd0))
      else $error("result did not start at row 0");

   // The input only stalls when the pipeline front holds data.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stage_valid[1] && rsp_valid && rsp_stall || stage_valid[1] && rsp_valid))
      else $error("input stalled with an empty front stage");
`endif

endmodule
